// ===== sv/fol_pkg.sv =====
// Package for the first-come lock: command and status codes, control struct.
// No dependencies; used by every module of the block.
package fol_pkg;

  localparam logic CMD_ACQUIRE = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [2:0] ST_GRANTED  = 3'd0;
  localparam logic [2:0] ST_QUEUED   = 3'd1;
  localparam logic [2:0] ST_HANDED   = 3'd2;
  localparam logic [2:0] ST_FREED    = 3'd3;
  localparam logic [2:0] ST_REJECTED = 3'd4;

  localparam logic [3:0] COUNT_MAX = 4'd15;

  // Controller commands to the datapath
  typedef struct packed {
    logic take;   // request accepted this cycle
    logic load;   // load the output register
  } fol_ctrl_t;

endpackage

// ===== sv/fol_req_if.sv =====
// Request channel of the lock: valid/ready handshake with command and id.
// No dependencies.
interface fol_req_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [3:0] requester_id;

  modport source (output valid, output cmd, output requester_id, input ready);
  modport sink (input valid, input cmd, input requester_id, output ready);
endinterface

// ===== sv/fol_rsp_if.sv =====
// Result channel of the lock: valid/ready handshake with status and counts.
// No dependencies.
interface fol_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [3:0] woken_id;
  logic [3:0] waiting_count;

  modport source (output valid, output status, output woken_id, output waiting_count,
                  input ready);
  modport sink (input valid, input status, input woken_id, input waiting_count,
                output ready);
endinterface

// ===== sv/fifo_ordered_resource_lock_top.sv =====
// First-come lock for one shared resource. An acquire is granted when the
// resource is free and nobody waits, otherwise its id joins a ring of
// QUEUE_SLOTS entries (one slot kept empty; a full ring rejects). A release
// hands the resource to the oldest waiter or frees it. Each request has two steps:
// it is accepted and the ring is read into a register, then the result is loaded
// into the output register once that is free or being read. A new request is
// accepted while a result still waits on rsp, but not before the last is loaded.
// Depends on fol_pkg, fol_req_if, fol_rsp_if, fol_ctrl, fol_dp.
module fifo_ordered_resource_lock_top #(
  parameter int QUEUE_SLOTS = 16
) (
  input logic      clk,
  input logic      rst,
  fol_req_if.sink  req,
  fol_rsp_if.source rsp
);

  fol_pkg::fol_ctrl_t ctrl;

  fol_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .ctrl      (ctrl)
  );

  fol_dp #(
    .QUEUE_SLOTS (QUEUE_SLOTS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .cmd           (req.cmd),
    .requester_id  (req.requester_id),
    .status        (rsp.status),
    .woken_id      (rsp.woken_id),
    .waiting_count (rsp.waiting_count)
  );

endmodule

// ===== sv/fol_ctrl.sv =====
// Controller of the lock: accept/load sequencing and output valid flag.
// Depends on fol_pkg.
module fol_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output fol_pkg::fol_ctrl_t ctrl
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LOAD = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;

  assign in_ready  = (state == S_IDLE);
  assign ctrl.take = in_valid && in_ready;
  assign ctrl.load = (state == S_LOAD) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (ctrl.take) state_next = S_LOAD;
      S_LOAD: if (ctrl.load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    priority if (ctrl.load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== sv/fol_dp.sv =====
// Datapath of the lock: wait ring memory, pointers, busy flag, output register.
// Depends on fol_pkg.
module fol_dp #(
  parameter int QUEUE_SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  fol_pkg::fol_ctrl_t ctrl,
  input  logic               cmd,
  input  logic [3:0]         requester_id,
  output logic [2:0]         status,
  output logic [3:0]         woken_id,
  output logic [3:0]         waiting_count
);

  localparam int PTR_W = $clog2(QUEUE_SLOTS);
  localparam int CNT_W = (PTR_W + 1 < 5) ? 5 : PTR_W + 1;
  localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_SLOTS - 1);

  logic [3:0]       ring [QUEUE_SLOTS];
  logic [3:0]       rd_data;
  logic [PTR_W-1:0] rp;
  logic [PTR_W-1:0] wp;
  logic             busy;
  logic [2:0]       st_q;

  logic [PTR_W-1:0] rp_adv;
  logic [PTR_W-1:0] wp_adv;
  logic             empty;
  logic             full;
  logic [2:0]       st_new;
  logic [CNT_W-1:0] diff;

  assign rp_adv = (rp == LAST) ? '0 : rp + 1'b1;
  assign wp_adv = (wp == LAST) ? '0 : wp + 1'b1;
  assign empty  = (rp == wp);
  assign full   = (wp_adv == rp);

  always_comb begin
    if (cmd == fol_pkg::CMD_ACQUIRE) begin
      priority if (!busy && empty) st_new = fol_pkg::ST_GRANTED;
      else if (full)               st_new = fol_pkg::ST_REJECTED;
      else                         st_new = fol_pkg::ST_QUEUED;
    end else begin
      st_new = empty ? fol_pkg::ST_FREED : fol_pkg::ST_HANDED;
    end
  end

  // ring occupancy, wrap-aware for any slot count
  always_comb begin
    if (wp >= rp) begin
      diff = CNT_W'(wp) - CNT_W'(rp);
    end else begin
      diff = CNT_W'(wp) + CNT_W'(QUEUE_SLOTS) - CNT_W'(rp);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rp   <= '0;
      wp   <= '0;
      busy <= 1'b0;
    end else if (ctrl.take) begin
      unique case (st_new)
        fol_pkg::ST_GRANTED: busy <= 1'b1;
        fol_pkg::ST_QUEUED:  wp   <= wp_adv;
        fol_pkg::ST_HANDED:  rp   <= rp_adv;
        fol_pkg::ST_FREED:   busy <= 1'b0;
        default: ;
      endcase
    end
  end

  // ring write and registered read of the oldest waiter
  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      if (st_new == fol_pkg::ST_QUEUED) ring[wp] <= requester_id;
      rd_data <= ring[rp];
      st_q    <= st_new;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      status        <= st_q;
      woken_id      <= (st_q == fol_pkg::ST_HANDED) ? rd_data : 4'd0;
      waiting_count <= (diff > CNT_W'(fol_pkg::COUNT_MAX)) ? fol_pkg::COUNT_MAX : diff[3:0];
    end
  end

endmodule

// ===== sv/fol_checker.sv =====
// Port-level checks for the first-come lock, bound to the top level.
// Depends on fol_pkg and fifo_ordered_resource_lock_top.
module fol_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [2:0] rsp_status,
  input logic [3:0] rsp_woken_id,
  input logic [3:0] rsp_waiting_count
);

  // held result must not move
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
      && $stable(rsp_woken_id) && $stable(rsp_waiting_count))
    else $error("result changed while stalled");

  a_woken_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != fol_pkg::ST_HANDED |-> rsp_woken_id == 4'd0)
    else $error("woken id set without hand-over");

  a_grant_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == fol_pkg::ST_GRANTED || rsp_status == fol_pkg::ST_FREED)
      |-> rsp_waiting_count == 4'd0)
    else $error("grant or free with waiters queued");

  a_queued_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == fol_pkg::ST_QUEUED |-> rsp_waiting_count != 4'd0)
    else $error("queued request not counted");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while previous still in work");

endmodule

bind fifo_ordered_resource_lock_top fol_checker u_fol_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_status        (rsp.status),
  .rsp_woken_id      (rsp.woken_id),
  .rsp_waiting_count (rsp.waiting_count)
);

// ===== bench/fifo_ordered_resource_lock_top_tb.sv =====
// Self-checking bench for the first-come resource lock: directed and random
// requests through fol_req_if, results checked field by field on fol_rsp_if.
// Depends on fol_pkg, fol_req_if, fol_rsp_if and fifo_ordered_resource_lock_top.
module fifo_ordered_resource_lock_top_tb;

  localparam int QUEUE_SLOTS = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int N_RANDOM    = 500;
  localparam int HOLD_CYCLES = 160;

  typedef struct packed {
    logic       cmd;
    logic [3:0] id;
  } lock_request_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] woken_id;
    logic [3:0] waiting_count;
  } lock_answer_t;

  logic clk = 1'b0;
  logic rst;

  fol_req_if req_ch ();
  fol_rsp_if rsp_ch ();

  fifo_ordered_resource_lock_top #(.QUEUE_SLOTS(QUEUE_SLOTS)) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  lock_request_t request_q [$];
  lock_answer_t  lock_answers_q [$];

  // Shadow of the lock state
  logic [3:0] waiter_ids [QUEUE_SLOTS];
  int         head_idx;
  int         tail_idx;
  bit         owned;

  int cyc;
  int errors;
  bit req_taken;
  int burst_left;
  int gap_left;
  int hold_left;
  int holds_done;
  int next_hold;
  int sink_mode;
  int n_req, n_grant, n_queue, n_hand, n_free, n_reject, deepest;

  task automatic flag_mismatch(input string what);
    errors++;
    $display("MISMATCH @%0d: %s", cyc, what);
  endtask

  task automatic queue_request(input logic cmd, input logic [3:0] id);
    lock_request_t r;
    r.cmd = cmd;
    r.id  = id;
    request_q.push_back(r);
  endtask

  function automatic void lock_predict(input logic cmd, input logic [3:0] id,
                                       output lock_answer_t a);
    int  n;
    bit  empty;
    empty = (head_idx == tail_idx);
    a.woken_id = 4'd0;
    if (cmd == fol_pkg::CMD_ACQUIRE) begin
      if (!owned && empty) begin
        owned = 1'b1;
        a.status = fol_pkg::ST_GRANTED;
        n_grant++;
      end else if ((tail_idx + 1) % QUEUE_SLOTS == head_idx) begin
        a.status = fol_pkg::ST_REJECTED;
        n_reject++;
      end else begin
        waiter_ids[tail_idx] = id;
        tail_idx = (tail_idx + 1) % QUEUE_SLOTS;
        a.status = fol_pkg::ST_QUEUED;
        n_queue++;
      end
    end else begin
      if (!empty) begin
        a.woken_id = waiter_ids[head_idx];
        head_idx = (head_idx + 1) % QUEUE_SLOTS;
        a.status = fol_pkg::ST_HANDED;
        n_hand++;
      end else begin
        owned = 1'b0;
        a.status = fol_pkg::ST_FREED;
        n_free++;
      end
    end
    n = (tail_idx + QUEUE_SLOTS - head_idx) % QUEUE_SLOTS;
    if (n > deepest) deepest = n;
    a.waiting_count = (n > 15) ? fol_pkg::COUNT_MAX : n[3:0];
    n_req++;
  endfunction

  // Sample both handshakes at the rising edge
  always @(posedge clk) begin : observe
    lock_answer_t want;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (lock_answers_q.size() == 0) begin
          flag_mismatch($sformatf("result with no request pending: status %0d",
                                  rsp_ch.status));
        end else begin
          want = lock_answers_q.pop_front();
          if (rsp_ch.status !== want.status)
            flag_mismatch($sformatf("status %0d, wanted %0d", rsp_ch.status, want.status));
          if (rsp_ch.woken_id !== want.woken_id)
            flag_mismatch($sformatf("woken_id %0d, wanted %0d",
                                    rsp_ch.woken_id, want.woken_id));
          if (rsp_ch.waiting_count !== want.waiting_count)
            flag_mismatch($sformatf("waiting_count %0d, wanted %0d",
                                    rsp_ch.waiting_count, want.waiting_count));
        end
      end
      req_taken <= req_ch.valid && req_ch.ready;
      if (req_ch.valid && req_ch.ready) begin
        lock_predict(req_ch.cmd, req_ch.requester_id, want);
        lock_answers_q.push_back(want);
      end
    end
  end

  // Request driver: bursts with random gaps, holds a request until taken
  always @(negedge clk) begin : drive
    lock_request_t item;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (req_ch.valid && !req_taken) begin
      // still waiting for ready
    end else if (gap_left > 0) begin
      req_ch.valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (request_q.size() > 0) begin
      item = request_q.pop_front();
      req_ch.valid        <= 1'b1;
      req_ch.cmd          <= item.cmd;
      req_ch.requester_id <= item.id;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 24);
        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      req_ch.valid <= 1'b0;
    end
  end

  // Long result-side hold-offs while requests are still queued up
  always @(negedge clk) begin : hold_off
    if (!rst) begin
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end else if (holds_done < 3 && cyc >= next_hold && request_q.size() > 20) begin
        hold_left  <= HOLD_CYCLES;
        holds_done <= holds_done + 1;
        next_hold  <= cyc + 700;
      end
    end
  end

  // Result-side stall pattern in one of four modes, redrawn at random
  always @(negedge clk) begin : sink_pace
    bit ok;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (cyc % 64 == 0) sink_mode <= $urandom_range(0, 3);
      case (sink_mode)
        0: ok = 1'b1;
        1: ok = ($urandom_range(0, 1) == 1);
        2: ok = (cyc % 4) != 3;
        default: ok = ($urandom_range(0, 3) == 0);
      endcase
      rsp_ch.ready <= ok && (hold_left == 0);
    end
  end

  always @(posedge clk) begin : watchdog
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cyc);
      $display("fifo_ordered_resource_lock_top_tb NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    int n;
    int plen;
    int pct;
    int acq_pct [5];
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.cmd = fol_pkg::CMD_ACQUIRE;
    req_ch.requester_id = 4'd0;
    rsp_ch.ready = 1'b0;
    cyc = 0;
    errors = 0;
    burst_left = 1;
    gap_left = 0;
    hold_left = 0;
    holds_done = 0;
    next_hold = 200;
    sink_mode = 0;
    head_idx = 0;
    tail_idx = 0;
    owned = 1'b0;
    n_req = 0; n_grant = 0; n_queue = 0; n_hand = 0; n_free = 0; n_reject = 0;
    deepest = 0;
    for (int i = 0; i < QUEUE_SLOTS; i++) waiter_ids[i] = 4'd0;

    // release with nothing held; its id is ignored
    queue_request(fol_pkg::CMD_RELEASE, 4'd5);
    queue_request(fol_pkg::CMD_ACQUIRE, 4'd15);
    queue_request(fol_pkg::CMD_ACQUIRE, 4'd0);
    queue_request(fol_pkg::CMD_ACQUIRE, 4'd0);   // same id waits twice
    queue_request(fol_pkg::CMD_RELEASE, 4'd7);
    queue_request(fol_pkg::CMD_RELEASE, 4'd9);
    queue_request(fol_pkg::CMD_RELEASE, 4'd0);
    queue_request(fol_pkg::CMD_ACQUIRE, 4'd3);
    // fill the ring to its last usable slot, then one too many
    for (int i = 1; i <= 15; i++) queue_request(fol_pkg::CMD_ACQUIRE, i[3:0]);
    queue_request(fol_pkg::CMD_ACQUIRE, 4'd0);
    queue_request(fol_pkg::CMD_RELEASE, 4'd15);

    // phases of varying acquire bias so the ring fills, rejects and drains
    acq_pct = '{95, 75, 50, 30, 10};
    n = 0;
    while (n < N_RANDOM) begin
      plen = $urandom_range(20, 70);
      pct  = acq_pct[$urandom_range(0, 4)];
      for (int k = 0; k < plen && n < N_RANDOM; k++) begin
        queue_request(($urandom_range(0, 99) < pct) ? fol_pkg::CMD_ACQUIRE
                                                    : fol_pkg::CMD_RELEASE,
                      4'($urandom_range(0, 15)));
        n++;
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (request_q.size() != 0 || req_ch.valid) @(posedge clk);
    while (lock_answers_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d requests: %0d granted, %0d queued, %0d handed over, %0d freed, %0d rejected",
             n_req, n_grant, n_queue, n_hand, n_free, n_reject);
    $display("deepest wait queue %0d, %0d long result hold-offs, %0d mismatches",
             deepest, holds_done, errors);
    if (errors == 0) begin
      $display("fifo_ordered_resource_lock_top_tb OK");
    end else begin
      $display("fifo_ordered_resource_lock_top_tb NOT OK");
    end
    $finish;
  end

endmodule
